>>> hdl/ipt_pkg.sv
// Package for the IPv4 prefix table: item and entry types, operation codes,
// controller states, command/status structs and helper functions.
// No dependencies; every other file imports it.
package ipt_pkg;

    // Prefix length limit, removed-count limit and the "no match yet" marker for search
    localparam logic [5:0] MAX_LEN   = 6'd32;
    localparam logic [5:0] NO_MATCH  = 6'd33;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [5:0]  prefix_len;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [5:0]  match_len;
        logic [8:0]  removed_count;
    } rsp_t;

    // One table entry as held in the memory
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [5:0]  length;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic scan_en;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic op_unused;
    } stat_t;

    function automatic logic [5:0] clamp_len(input logic [5:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // Mask of the top len bits; len is at most 32
    function automatic logic [31:0] top_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
        begin
            m = 32'd0;
        end
        else
        begin
            m = 32'hFFFF_FFFF << (MAX_LEN - len);
        end
        return m;
    endfunction

endpackage

>>> hdl/ip_prefix_table.sv
// IPv4 prefix table: insert, delete and shortest-prefix search over TABLE_ENTRIES prefixes.
// Operation code 3 goes straight to its result; search and delete sweep every entry;
// insert sweeps up to the lowest free entry (every entry if the table is full).
// Throughput: one operation at a time, set by the sweep of the entry memory;
// a new request can be taken in the cycle the result turns valid.
// Reset: a clearing pass over every entry runs first; no request is taken until it ends.
module ip_prefix_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ipt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ipt_pkg::rsp_t rsp
);
    import ipt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    ipt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table storage and evaluation
    ipt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

>>> hdl/ipt_ctrl.sv
// Controller for the IPv4 prefix table: sequences the clearing pass, the
// per-operation sweep and the result hand-off. Depends on ipt_pkg.
module ipt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  ipt_pkg::stat_t stat,
    output ipt_pkg::cmd_t  cmd
);
    import ipt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = stat.op_unused ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                if (stat.scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_RUN:
            begin
                cmd.scan_en = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Result valid flag: set on load, dropped on transfer
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result loaded over an untaken one");

    // A new result only appears after the done state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid rose outside done state");

    // No request taken during the clearing pass or a sweep
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_RUN) |-> !req_ready)
        else $error("request accepted while busy");

    // Clearing and sweeping never share the memory write port
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_en && cmd.scan_en))
        else $error("clear and scan active together");
`endif

endmodule

>>> hdl/ipt_datapath.sv
// Datapath for the IPv4 prefix table: entry memory, sweep index, per-entry
// evaluation, accumulators and the result register. Depends on ipt_pkg.
module ipt_datapath #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ipt_pkg::req_t  req,
    input  ipt_pkg::cmd_t  cmd,
    output ipt_pkg::stat_t stat,
    output ipt_pkg::rsp_t  rsp
);
    import ipt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];

    // Captured operation
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [5:0]  len_reg;

    // Sweep control
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_done_reg, rd_done_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0] ev_idx_reg;
    logic             ev_last_reg;
    entry_t           rd_data_reg;

    // Accumulators
    logic       placed_reg, placed_next;
    logic [8:0] count_reg, count_next;
    logic [5:0] best_reg, best_next;

    // Memory write port
    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;

    // Evaluation of the entry read last cycle
    logic   ev_on;
    logic   is_free, del_match, srch_match;
    logic   rd_issue;
    logic [31:0] m;
    rsp_t   rsp_next;

    assign ev_on = cmd.scan_en && ev_valid_reg;
    assign m     = top_mask(rd_data_reg.length);

    always_comb
    begin
        is_free    = (op_reg == OP_INSERT) && !rd_data_reg.valid && !placed_reg;
        del_match  = (op_reg == OP_DELETE) && rd_data_reg.valid
                     && (rd_data_reg.address == addr_reg)
                     && (rd_data_reg.length == len_reg);
        srch_match = (op_reg == OP_SEARCH) && rd_data_reg.valid
                     && (rd_data_reg.address[31:24] == addr_reg[31:24])
                     && (((rd_data_reg.address ^ addr_reg) & m) == 32'd0);
    end

    // Accumulator updates
    always_comb
    begin
        placed_next = placed_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        if (cmd.capture)
        begin
            placed_next = 1'b0;
            count_next  = 9'd0;
            best_next   = NO_MATCH;
        end
        else if (ev_on)
        begin
            if (is_free)
                placed_next = 1'b1;
            if (del_match && count_reg != COUNT_MAX)
                count_next = count_reg + 9'd1;
            if (srch_match && rd_data_reg.length < best_reg)
                best_next = rd_data_reg.length;
        end
    end

    // Write port: clearing pass, insert fill or delete invalidate
    always_comb
    begin
        we = 1'b0;
        wa = ev_idx_reg;
        wd = '0;
        if (cmd.clr_en)
        begin
            we = 1'b1;
            wa = rd_idx_reg;
        end
        else if (ev_on && is_free)
        begin
            we = 1'b1;
            wd.valid   = 1'b1;
            wd.address = addr_reg;
            wd.length  = len_reg;
        end
        else if (ev_on && del_match)
        begin
            we = 1'b1;
        end
    end

    // Sweep index
    assign rd_issue = cmd.scan_en && !rd_done_reg;

    always_comb
    begin
        rd_idx_next   = rd_idx_reg;
        rd_done_next  = rd_done_reg;
        ev_valid_next = 1'b0;
        if (cmd.capture)
        begin
            rd_idx_next  = '0;
            rd_done_next = 1'b0;
        end
        else if (cmd.clr_en || rd_issue)
        begin
            rd_idx_next   = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);
            ev_valid_next = rd_issue;
            if (rd_issue && rd_idx_reg == LAST_IDX)
                rd_done_next = 1'b1;
        end
    end

    // Status back to the controller
    assign stat.clr_last  = cmd.clr_en && (rd_idx_reg == LAST_IDX);
    assign stat.scan_last = ev_on && (ev_last_reg || is_free);
    assign stat.op_unused = !(req.operation == OP_INSERT || req.operation == OP_DELETE
                              || req.operation == OP_SEARCH);

    // Result assembly
    always_comb
    begin
        rsp_next = '0;
        if (op_reg == OP_INSERT)
            rsp_next.status = !placed_reg;
        if (op_reg == OP_DELETE)
            rsp_next.removed_count = count_reg;
        if (op_reg == OP_SEARCH && best_reg != NO_MATCH)
        begin
            rsp_next.hit       = 1'b1;
            rsp_next.match_len = best_reg;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[rd_idx_reg];
    end

    // Sweep control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            rd_done_reg  <= 1'b1;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg   <= rd_idx_next;
            rd_done_reg  <= rd_done_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    // Payload and accumulator registers
    always_ff @(posedge clk)
    begin
        ev_idx_reg  <= rd_idx_reg;
        ev_last_reg <= (rd_idx_reg == LAST_IDX);
        placed_reg  <= placed_next;
        count_reg   <= count_next;
        best_reg    <= best_next;
        if (cmd.capture)
        begin
            op_reg   <= req.operation;
            addr_reg <= req.address;
            len_reg  <= clamp_len(req.prefix_len);
        end
        if (cmd.out_load)
            rsp <= rsp_next;
    end

endmodule

>>> test/ipt_scoreboard_pkg.sv
// Scoreboard for the IPv4 prefix table testbench: a mirror of the prefix
// store, the queue of outstanding responses and the field-by-field check.
// Depends on ipt_pkg for the request/response structs and operation codes.
`timescale 1ns / 100ps

package ipt_scoreboard_pkg;

    import ipt_pkg::*;

    localparam int         TABLE_ENTRIES = 256;
    // Operation code 3 has no function: the block answers with an all-zero response
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    class prefix_scoreboard;

        bit        used     [TABLE_ENTRIES];
        bit [31:0] pfx_addr [TABLE_ENTRIES];
        bit [5:0]  pfx_len  [TABLE_ENTRIES];
        rsp_t      awaited  [$];
        int        mismatches;

        function new();
            mismatches = 0;
            foreach (used[i])
            begin
                used[i] = 1'b0;
            end
        endfunction

        // Update the mirror for an accepted request and queue its response
        function void note_request(req_t r);
            rsp_t      want;
            bit [5:0]  key_len;
            bit [31:0] mask;
            int        slot;
            int        gone;
            int        best;
            int        i;
            want    = '0;
            key_len = (r.prefix_len > MAX_LEN) ? MAX_LEN : r.prefix_len;
            case (r.operation)
                OP_INSERT:
                begin
                    // Lowest free slot; drop and flag when none left
                    slot = -1;
                    for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                    begin
                        if (!used[i])
                        begin
                            slot = i;
                        end
                    end
                    if (slot < 0)
                    begin
                        want.status = 1'b1;
                    end
                    else
                    begin
                        used[slot]     = 1'b1;
                        pfx_addr[slot] = r.address;
                        pfx_len[slot]  = key_len;
                    end
                end
                OP_DELETE:
                begin
                    gone = 0;
                    for (i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (used[i] && pfx_addr[i] == r.address && pfx_len[i] == key_len)
                        begin
                            used[i] = 1'b0;
                            gone++;
                        end
                    end
                    want.removed_count = (gone > COUNT_MAX) ? COUNT_MAX : gone[8:0];
                end
                OP_SEARCH:
                begin
                    // Same first octet, then agreement on the top length bits
                    best = NO_MATCH;
                    for (i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (used[i] && pfx_addr[i][31:24] == r.address[31:24])
                        begin
                            mask = (pfx_len[i] == 0) ? 32'd0
                                                     : (32'hFFFF_FFFF << (32 - pfx_len[i]));
                            if ((pfx_addr[i] & mask) == (r.address & mask) && pfx_len[i] < best)
                            begin
                                best = pfx_len[i];
                            end
                        end
                    end
                    if (best <= MAX_LEN)
                    begin
                        want.hit       = 1'b1;
                        want.match_len = best[5:0];
                    end
                end
                default:
                begin
                    // OP_UNUSED: nothing changes, response stays all zero
                end
            endcase
            awaited.push_back(want);
        endfunction

        function void report(string what, rsp_t want, rsp_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s: status %0b/%0b hit %0b/%0b match_len %0d/%0d removed %0d/%0d (exp/act)",
                         $time, what, want.status, got.status, want.hit, got.hit,
                         want.match_len, got.match_len, want.removed_count, got.removed_count);
            end
        endfunction

        // Compare an accepted response with the oldest outstanding one
        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report("response with nothing outstanding", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.hit !== want.hit ||
                got.match_len !== want.match_len || got.removed_count !== want.removed_count)
            begin
                report("response mismatch", want, got);
            end
        endfunction

    endclass

endpackage

>>> test/ip_prefix_table_tb.sv
// Testbench top for ip_prefix_table: directed and random insert/delete/search
// traffic with random idling on both channels, checked against the scoreboard.
// Depends on ipt_pkg and ipt_scoreboard_pkg.
`timescale 1ns / 100ps

module ip_prefix_table_tb;

    import ipt_pkg::*;
    import ipt_scoreboard_pkg::*;

    localparam int N_MIXED       = 130;
    localparam int N_FILL        = TABLE_ENTRIES + 2;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // No idling on either side while set
    bit quiet      = 1'b0;
    int ready_left = 0;

    prefix_scoreboard sb = new();

    ip_prefix_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Response side: ready held high or low in bursts of random length
    always @(negedge clk)
    begin
        if (quiet)
        begin
            ready_left = 0;
            rsp_ready <= 1'b1;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 2) != 0);
            ready_left = $urandom_range(0, 8);
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            sb.check_response(rsp);
        end
    end

    function automatic req_t make_req(logic [1:0] op, logic [31:0] addr, logic [5:0] len);
        req_t r;
        r.operation  = op;
        r.address    = addr;
        r.prefix_len = len;
        return r;
    endfunction

    // Drive one request and hold it until the transfer completes
    task automatic send(req_t item);
        @(negedge clk);
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(item);
    endtask

    // Random gap on the request side
    task automatic idle_gap();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 9);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Random address, biased towards a few first octets so prefixes collide
    function automatic logic [31:0] rand_address();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(0, 3))
            0:       a[31:24] = 8'h00;
            1:       a[31:24] = 8'hFF;
            2:       a[31:24] = 8'h0A;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [5:0] rand_length();
        if ($urandom_range(0, 7) == 0)
        begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(0, 32));
    endfunction

    // Lengths above 32 are taken as 32, so use them as an alternative spelling
    function automatic logic [5:0] alias_len(logic [5:0] len);
        if (len == MAX_LEN && $urandom_range(0, 1) == 0)
        begin
            return 6'($urandom_range(33, 63));
        end
        return len;
    endfunction

    function automatic int first_entry();
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (sb.used[i])
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Random occupied entry, or -1 when the table is empty
    function automatic int pick_entry();
        int n;
        int k;
        int i;
        n = 0;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (sb.used[i])
            begin
                n++;
            end
        end
        if (n == 0)
        begin
            return -1;
        end
        k = $urandom_range(0, n - 1);
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (sb.used[i])
            begin
                if (k == 0)
                begin
                    return i;
                end
                k--;
            end
        end
        return -1;
    endfunction

    // Address under an entry's prefix; how 1 flips a prefix bit,
    // how 2 flips a first-octet bit below a short prefix
    function automatic logic [31:0] probe_address(int e, int how);
        logic [31:0] base;
        logic [31:0] mask;
        logic [31:0] a;
        logic [5:0]  len;
        int          j;
        base = sb.pfx_addr[e];
        len  = sb.pfx_len[e];
        mask = (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
        a    = (base & mask) | ($urandom & ~mask);
        a[31:24] = base[31:24];
        if (how == 1 && len != 0)
        begin
            j    = 31 - $urandom_range(0, len - 1);
            a[j] = ~a[j];
        end
        else if (how == 2 && len < 8)
        begin
            j    = 31 - len - $urandom_range(0, 7 - len);
            a[j] = ~a[j];
        end
        return a;
    endfunction

    initial
    begin
        req_t        item;
        logic [31:0] k_addr;
        logic [5:0]  k_len;
        int          e;
        int          n;
        int          sel;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, zero-length and full-length prefixes,
        // short prefixes against other octets, length clamping, unused op
        send(make_req(OP_SEARCH, 32'h0000_0000, 6'd0));
        send(make_req(OP_INSERT, 32'h0000_0000, 6'd0));
        send(make_req(OP_SEARCH, 32'h00FF_FFFF, 6'd0));
        send(make_req(OP_SEARCH, 32'h0100_0000, 6'd0));
        send(make_req(OP_INSERT, 32'hFFFF_FFFF, 6'd32));
        send(make_req(OP_INSERT, 32'hFFFF_FFFF, 6'd63));
        send(make_req(OP_SEARCH, 32'hFFFF_FFFF, 6'd0));
        send(make_req(OP_SEARCH, 32'hFFFF_FFFE, 6'd63));
        send(make_req(OP_INSERT, 32'hC0A8_0000, 6'd16));
        send(make_req(OP_INSERT, 32'hC0A8_0100, 6'd24));
        send(make_req(OP_INSERT, 32'hC000_0000, 6'd4));
        send(make_req(OP_SEARCH, 32'hC0A8_01FF, 6'd0));
        send(make_req(OP_SEARCH, 32'hC100_0000, 6'd0));
        send(make_req(OP_DELETE, 32'hC000_0000, 6'd4));
        send(make_req(OP_SEARCH, 32'hC0A8_01FF, 6'd0));
        send(make_req(OP_DELETE, 32'hFFFF_FFFF, 6'd33));
        send(make_req(OP_DELETE, 32'hFFFF_FFFF, 6'd32));
        send(make_req(OP_UNUSED, 32'hFFFF_FFFF, 6'd63));
        send(make_req(OP_SEARCH, 32'hC0A8_0000, 6'd63));
        send(make_req(OP_DELETE, 32'h0000_0000, 6'd0));
        send(make_req(OP_INSERT, 32'h8000_0001, 6'd31));
        send(make_req(OP_SEARCH, 32'h8000_0000, 6'd0));
        send(make_req(OP_SEARCH, 32'h8000_0003, 6'd0));

        // Mixed traffic, mostly aimed at prefixes already in the table
        for (n = 0; n < N_MIXED; n++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                quiet = !quiet;
            end
            e   = pick_entry();
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                if (e >= 0 && $urandom_range(0, 3) == 0)
                begin
                    item = make_req(OP_INSERT, sb.pfx_addr[e], alias_len(sb.pfx_len[e]));
                end
                else
                begin
                    item = make_req(OP_INSERT, rand_address(), rand_length());
                end
            end
            else if (sel < 60)
            begin
                if (e >= 0 && $urandom_range(0, 3) != 0)
                begin
                    item = make_req(OP_DELETE, sb.pfx_addr[e], alias_len(sb.pfx_len[e]));
                end
                else
                begin
                    item = make_req(OP_DELETE, rand_address(), rand_length());
                end
            end
            else if (sel < 95)
            begin
                if (e >= 0)
                begin
                    item = make_req(OP_SEARCH, probe_address(e, $urandom_range(0, 2)),
                                    6'($urandom_range(0, 63)));
                end
                else
                begin
                    item = make_req(OP_SEARCH, rand_address(), 6'($urandom_range(0, 63)));
                end
            end
            else
            begin
                item = make_req(OP_UNUSED, $urandom, 6'($urandom_range(0, 63)));
            end
            send(item);
            idle_gap();
        end

        // Empty the table one key at a time
        quiet = 1'b0;
        for (e = first_entry(); e >= 0; e = first_entry())
        begin
            send(make_req(OP_DELETE, sb.pfx_addr[e], alias_len(sb.pfx_len[e])));
            idle_gap();
        end

        // Final stretch without idling: fill with one key past capacity,
        // search it, then remove every copy at once
        quiet  = 1'b1;
        k_addr = $urandom;
        k_len  = rand_length();
        if (k_len > MAX_LEN)
        begin
            k_len = MAX_LEN;
        end
        for (n = 0; n < N_FILL; n++)
        begin
            send(make_req(OP_INSERT, k_addr, alias_len(k_len)));
        end
        send(make_req(OP_SEARCH, probe_address(0, 0), 6'd0));
        send(make_req(OP_SEARCH, probe_address(0, 1), 6'd0));
        send(make_req(OP_SEARCH, rand_address(), 6'd0));
        send(make_req(OP_DELETE, k_addr, alias_len(k_len)));
        send(make_req(OP_SEARCH, k_addr, 6'd0));

        @(negedge clk);
        req_valid <= 1'b0;

        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.awaited.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ipt_pkg.sv
hdl/ipt_ctrl.sv
hdl/ipt_datapath.sv
hdl/ip_prefix_table.sv
test/ipt_scoreboard_pkg.sv
test/ip_prefix_table_tb.sv
